/* rtl/drmlp_pkg.sv */
// Shared types, constants and helpers of the dense ReLU MLP inference block.
package drmlp_pkg;

    // Sizing of the network stores.
    localparam int MAX_WEIGHT_LAYERS = 4;
    localparam int MAX_WIDTH         = 16;
    localparam int DATA_BITS         = 16;
    localparam int FRAC_BITS         = DATA_BITS / 2;

    // Field widths of the stream items.
    localparam int LSEL_W   = 2;
    localparam int IDX_W    = 4;
    localparam int ACTION_W = 2;
    localparam int LAYER_W  = $clog2(MAX_WEIGHT_LAYERS);
    localparam int SIZE_W   = 5;
    localparam int LCNT_W   = 3;

    // Store address widths.
    localparam int WADDR_W = LAYER_W + 2 * IDX_W;
    localparam int BADDR_W = LAYER_W + IDX_W;
    localparam int AADDR_W = 1 + IDX_W;

    // Accumulator: full products plus headroom for every column and the bias.
    localparam int PROD_W = 2 * DATA_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_WIDTH) + 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int NUM_CFG    = 6;

    // Packed stream widths.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_WEIGHT = 2'd0,
        ACT_LOAD_BIAS   = 2'd1,
        ACT_ELEMENT     = 2'd2,
        ACT_UNUSED      = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYER_COUNT = 3'd0,
        CFG_SIZE_INPUT  = 3'd1,
        CFG_SIZE_HID1   = 3'd2,
        CFG_SIZE_HID2   = 3'd3,
        CFG_SIZE_HID3   = 3'd4,
        CFG_SIZE_FINAL  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_BIAS,
        S_WB,
        S_ORD,
        S_OLD,
        S_OWAIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               w_we;
        logic               b_we;
        logic               x_we;
        logic               rd;
        logic               mul;
        logic               acc;
        logic               acc_first;
        logic               bias_add;
        logic               wb;
        logic               out_load;
        logic               out_last;
        logic [LAYER_W-1:0] layer;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic               act_bank;
        logic [IDX_W-1:0]   act_idx;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } t_dp_sts;

    // Clamp a layer size register into [1, MAX_WIDTH].
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0)
            r = SIZE_W'(1);
        else if (s > SIZE_W'(MAX_WIDTH))
            r = SIZE_W'(MAX_WIDTH);
        return r;
    endfunction

endpackage

/* rtl/dense_relu_mlp_inference.sv */
// Top level of the dense ReLU MLP inference block.
// Weights (action 0) and biases (action 1) are written one word per input
// transfer, as are input elements (action 2). The element marked last starts
// evaluation, during which no input is taken: each multiply-accumulate steps
// through read, multiply and accumulate on the single shared 16x16 multiplier,
// and each neuron then adds its bias and writes back. The output neurons then
// leave one at a time, each held until the downstream side takes it, the last
// with tlast.
// Values are signed Q8.8, rounded half up, saturated and passed through ReLU.
module dense_relu_mlp_inference
    import drmlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: layer_sel[1:0], row_sel[5:2], col_sel[9:6], value_in[25:10], zero fill.
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: action[1:0].
    input  logic [ACTION_W-1:0]   s_axis_tuser,
    input  logic                  s_axis_tlast,
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: value_out[15:0], out_index[19:16], zero fill.
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    output logic                  m_axis_tlast
);

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [DATA_BITS-1:0] value_out;
    logic [IDX_W-1:0]     out_index;

    assign o_cfg_ready = 1'b1;

    drmlp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd)
    );

    drmlp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_layer_sel (s_axis_tdata[1:0]),
        .i_row_sel   (s_axis_tdata[5:2]),
        .i_col_sel   (s_axis_tdata[9:6]),
        .i_value_in  (s_axis_tdata[25:10]),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_value_out (value_out),
        .o_out_index (out_index),
        .o_last_out  (m_axis_tlast)
    );

    // Pack the result fields, lowest first.
    assign m_axis_tvalid = sts.out_valid;
    assign m_axis_tdata  = {4'b0, out_index, value_out};

endmodule

/* rtl/drmlp_ctrl.sv */
// Controller of the MLP block: configuration registers, sequencing of loads,
// layer evaluation and output emission.
module drmlp_ctrl
    import drmlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic [ACTION_W-1:0]   i_in_action,
    input  logic                  i_in_last,
    input  t_dp_sts               i_sts,
    output logic                  o_in_ready,
    output t_dp_cmd               o_cmd
);

    t_state             r_state, n_state;
    logic [LCNT_W-1:0]  r_layer_count;
    logic [SIZE_W-1:0]  r_size [NUM_CFG-1];
    logic [LAYER_W-1:0] r_layer, n_layer;
    logic [IDX_W-1:0]   r_row, n_row;
    logic [IDX_W-1:0]   r_col, n_col;

    logic [LCNT_W-1:0]  lc_clamped;
    logic [LAYER_W-1:0] last_layer;
    logic [SIZE_W-1:0]  ns, nd, nf;
    logic               col_last, row_last, layer_last, out_last;
    logic               in_xfer;

    // Configuration writes; indexes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= LCNT_W'(2);
            for (int i = 0; i < NUM_CFG - 1; i++) begin
                r_size[i] <= SIZE_W'(16);
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LAYER_COUNT: r_layer_count <= i_cfg_data[LCNT_W-1:0];
                CFG_SIZE_INPUT:  r_size[0] <= i_cfg_data;
                CFG_SIZE_HID1:   r_size[1] <= i_cfg_data;
                CFG_SIZE_HID2:   r_size[2] <= i_cfg_data;
                CFG_SIZE_HID3:   r_size[3] <= i_cfg_data;
                CFG_SIZE_FINAL:  r_size[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Layer count clamped to [2, MAX_WEIGHT_LAYERS + 1]; weight layers = count - 1.
    always_comb begin
        lc_clamped = r_layer_count;
        if (r_layer_count < LCNT_W'(2))
            lc_clamped = LCNT_W'(2);
        else if (r_layer_count > LCNT_W'(MAX_WEIGHT_LAYERS + 1))
            lc_clamped = LCNT_W'(MAX_WEIGHT_LAYERS + 1);
    end

    assign last_layer = LAYER_W'(lc_clamped - LCNT_W'(2));
    assign ns = clamp_size(r_size[r_layer]);
    assign nd = clamp_size(r_size[LCNT_W'(r_layer) + LCNT_W'(1)]);
    assign nf = clamp_size(r_size[LCNT_W'(lc_clamped - LCNT_W'(1))]);

    assign col_last   = ({1'b0, r_col} == ns - SIZE_W'(1));
    assign row_last   = ({1'b0, r_row} == nd - SIZE_W'(1));
    assign layer_last = (r_layer == last_layer);
    assign out_last   = ({1'b0, r_row} == nf - SIZE_W'(1));
    assign in_xfer    = i_in_valid && o_in_ready;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_layer <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_layer <= n_layer;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_layer    = r_layer;
        n_row      = r_row;
        n_col      = r_col;
        o_in_ready = 1'b0;

        o_cmd           = '0;
        o_cmd.layer     = r_layer;
        o_cmd.row       = r_row;
        o_cmd.col       = r_col;
        o_cmd.act_bank  = r_layer[0];
        o_cmd.act_idx   = r_col;
        o_cmd.acc_first = (r_col == '0);
        o_cmd.out_last  = out_last;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer) begin
                    case (i_in_action)
                        ACT_LOAD_WEIGHT: o_cmd.w_we = 1'b1;
                        ACT_LOAD_BIAS:   o_cmd.b_we = 1'b1;
                        ACT_ELEMENT: begin
                            o_cmd.x_we = 1'b1;
                            if (i_in_last) begin
                                n_layer = '0;
                                n_row   = '0;
                                n_col   = '0;
                                n_state = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (col_last) begin
                    n_state = S_BIAS;
                end else begin
                    n_col   = r_col + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_BIAS: begin
                o_cmd.bias_add = 1'b1;
                n_state        = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_col    = '0;
                if (!row_last) begin
                    n_row   = r_row + IDX_W'(1);
                    n_state = S_RD;
                end else if (!layer_last) begin
                    n_row   = '0;
                    n_layer = r_layer + LAYER_W'(1);
                    n_state = S_RD;
                end else begin
                    n_row   = '0;
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                // Final layer's outputs sit in the bank the last layer wrote.
                o_cmd.rd       = 1'b1;
                o_cmd.act_bank = ~r_layer[0];
                o_cmd.act_idx  = r_row;
                n_state        = S_OLD;
            end
            S_OLD: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OWAIT;
            end
            S_OWAIT: begin
                if (!i_sts.out_valid) begin
                    if (out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + IDX_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // An input transfer never coincides with a pending result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !i_sts.out_valid)
        else $error("input taken while a result is pending");

    // A final element starts evaluation on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_action == ACT_ELEMENT && i_in_last) |=> r_state == S_RD)
        else $error("final element did not start evaluation");

    // The column counter stays inside the source layer during accumulation.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ({1'b0, r_col} < ns))
        else $error("column counter beyond source layer");

    // A loaded result is shown on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OLD) |=> i_sts.out_valid)
        else $error("result not presented after load");

endmodule

/* rtl/drmlp_dp.sv */
// Datapath of the MLP block: weight, bias and activation stores, the shared
// multiply-accumulate unit, rounding and ReLU, and the output register.
module drmlp_dp
    import drmlp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [LSEL_W-1:0]    i_layer_sel,
    input  logic [IDX_W-1:0]     i_row_sel,
    input  logic [IDX_W-1:0]     i_col_sel,
    input  logic [DATA_BITS-1:0] i_value_in,
    input  logic                 i_out_ready,
    output t_dp_sts              o_sts,
    output logic [DATA_BITS-1:0] o_value_out,
    output logic [IDX_W-1:0]     o_out_index,
    output logic                 o_last_out
);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'((1 << (DATA_BITS - 1)) - 1);

    logic [DATA_BITS-1:0] r_wmem [MAX_WEIGHT_LAYERS * MAX_WIDTH * MAX_WIDTH];
    logic [DATA_BITS-1:0] r_bmem [MAX_WEIGHT_LAYERS * MAX_WIDTH];
    logic [DATA_BITS-1:0] r_amem [2 * MAX_WIDTH];

    logic [DATA_BITS-1:0]    r_w_rd, r_b_rd, r_a_rd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic [DATA_BITS-1:0]     r_out_value;
    logic [IDX_W-1:0]         r_out_index;
    logic                     r_out_last;

    logic [WADDR_W-1:0]       w_addr;
    logic [BADDR_W-1:0]       b_addr;
    logic [AADDR_W-1:0]       a_waddr, a_raddr;
    logic [DATA_BITS-1:0]     a_wdata;
    logic signed [ACC_W-1:0]  rounded;
    logic [DATA_BITS-1:0]     act_result;

    // Store addresses: loads take the stream fields, evaluation the counters.
    always_comb begin
        if (i_cmd.w_we || i_cmd.b_we) begin
            w_addr = {i_layer_sel[LAYER_W-1:0], i_row_sel, i_col_sel};
            b_addr = {i_layer_sel[LAYER_W-1:0], i_row_sel};
        end else begin
            w_addr = {i_cmd.layer, i_cmd.row, i_cmd.col};
            b_addr = {i_cmd.layer, i_cmd.row};
        end
        if (i_cmd.x_we) begin
            a_waddr = {1'b0, i_row_sel};
            a_wdata = i_value_in;
        end else begin
            a_waddr = {~i_cmd.layer[0], i_cmd.row};
            a_wdata = act_result;
        end
        a_raddr = {i_cmd.act_bank, i_cmd.act_idx};
    end

    // Weight memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.w_we)
            r_wmem[w_addr] <= i_value_in;
        if (i_cmd.rd)
            r_w_rd <= r_wmem[w_addr];
    end

    // Bias memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.b_we)
            r_bmem[b_addr] <= i_value_in;
        if (i_cmd.rd)
            r_b_rd <= r_bmem[b_addr];
    end

    // Activation memory: ping in the lower half, pong in the upper half.
    always_ff @(posedge i_clk) begin
        if (i_cmd.x_we || i_cmd.wb)
            r_amem[a_waddr] <= a_wdata;
        if (i_cmd.rd)
            r_a_rd <= r_amem[a_raddr];
    end

    // Multiply, then accumulate; the bias enters scaled to the product format.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul)
            r_prod <= $signed(r_w_rd) * $signed(r_a_rd);
        if (i_cmd.acc) begin
            if (i_cmd.acc_first)
                r_acc <= ACC_W'(r_prod);
            else
                r_acc <= r_acc + ACC_W'(r_prod);
        end else if (i_cmd.bias_add) begin
            r_acc <= r_acc + (ACC_W'($signed(r_b_rd)) <<< FRAC_BITS);
        end
    end

    // Round half up, saturate, then ReLU clears negative results.
    always_comb begin
        rounded = (r_acc + ROUND_HALF) >>> FRAC_BITS;
        if (rounded < 0)
            act_result = '0;
        else if (rounded > OUT_MAX)
            act_result = OUT_MAX[DATA_BITS-1:0];
        else
            act_result = rounded[DATA_BITS-1:0];
    end

    // Output register; cleared once the downstream side takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= r_a_rd;
            r_out_index <= i_cmd.row;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_value_out     = r_out_value;
    assign o_out_index     = r_out_index;
    assign o_last_out      = r_out_last;

    // Output register is only reloaded after its previous transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("output register overwritten");

    // Loads and evaluation never share a cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.w_we || i_cmd.b_we || i_cmd.x_we) |-> !(i_cmd.rd || i_cmd.wb))
        else $error("load during evaluation");

    // Written-back activations are never negative.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |-> !act_result[DATA_BITS-1])
        else $error("negative activation written");

endmodule

/* tb/tb_dense_relu_mlp_inference.sv */
// Self-checking testbench of the dense ReLU MLP inference block.
`timescale 1ns / 1ps

module tb_dense_relu_mlp_inference;
    import drmlp_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int DRAIN_TAIL  = 40;
    localparam int RANDOM_ITEMS = 30;
    localparam int RANDOM_RESULTS = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(NUM_CFG);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(NUM_CFG + 1);

    typedef struct {
        logic signed [DATA_BITS-1:0] value;
        logic [IDX_W-1:0]            index;
        logic                        last;
    } t_neuron_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ACTION_W-1:0]   s_axis_tuser = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;

    // Shadow copy of the network state and the register file.
    logic signed [DATA_BITS-1:0] weight_mem [MAX_WEIGHT_LAYERS][MAX_WIDTH][MAX_WIDTH];
    logic signed [DATA_BITS-1:0] bias_mem [MAX_WEIGHT_LAYERS][MAX_WIDTH];
    logic signed [DATA_BITS-1:0] act_mem [2][MAX_WIDTH];
    bit                          weight_set [MAX_WEIGHT_LAYERS][MAX_WIDTH][MAX_WIDTH];
    bit                          bias_set [MAX_WEIGHT_LAYERS][MAX_WIDTH];
    bit                          ping_set [MAX_WIDTH];
    logic [CFG_DATA_W-1:0]       cfg_shadow [NUM_CFG];

    t_neuron_out expected_outputs [$];
    int          err_count = 0;
    int          outputs_seen = 0;
    int          items_sent = 0;
    bit          send_gaps = 1'b0;
    bit          stall_on = 1'b0;
    int          stall_left = 0;
    int          stall_draw;

    dense_relu_mlp_inference dut (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Run limit, far beyond the slowest correct run.
    initial begin
        #(5_000_000);
        $display("tb_dense_relu_mlp_inference: errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Compare one output transfer with the oldest expected neuron.
    task automatic check_output;
        t_neuron_out exp_out;
        if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected output value %h", m_axis_tdata[15:0]));
        end else begin
            exp_out = expected_outputs.pop_front();
            if (m_axis_tdata[15:0] !== exp_out.value)
                report_mismatch($sformatf("neuron %0d value %h, expected %h",
                    exp_out.index, m_axis_tdata[15:0], exp_out.value));
            if (m_axis_tdata[19:16] !== exp_out.index)
                report_mismatch($sformatf("index %0d, expected %0d",
                    m_axis_tdata[19:16], exp_out.index));
            if (m_axis_tlast !== exp_out.last)
                report_mismatch($sformatf("neuron %0d last %b, expected %b",
                    exp_out.index, m_axis_tlast, exp_out.last));
        end
        outputs_seen++;
    endtask

    // Output side: check each transfer, then, when stalls are on, stall for a random while.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            check_output();
            stall_draw = stall_on ? $urandom_range(0, 11) : 0;
            stall_left    <= stall_draw;
            m_axis_tready <= (stall_draw == 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left    <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    function automatic int clamped_size(input int layer);
        int s;
        s = cfg_shadow[1 + layer];
        if (s < 1) s = 1;
        if (s > MAX_WIDTH) s = MAX_WIDTH;
        return s;
    endfunction

    function automatic int weight_layers();
        int lc;
        lc = cfg_shadow[CFG_LAYER_COUNT] & 7;
        if (lc < 2) lc = 2;
        if (lc > MAX_WEIGHT_LAYERS + 1) lc = MAX_WEIGHT_LAYERS + 1;
        return lc - 1;
    endfunction

    // Multiply-accumulate, bias, round half up, saturate and ReLU.
    function automatic logic signed [DATA_BITS-1:0] neuron_activation(
        input int layer, input int row, input int sources, input int bank);
        longint acc;
        longint lim;
        longint r;
        lim = longint'(1) <<< 62;
        acc = 0;
        for (int c = 0; c < sources; c++) begin
            acc += longint'(weight_mem[layer][row][c]) * longint'(act_mem[bank][c]);
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
        end
        acc += longint'(bias_mem[layer][row]) <<< FRAC_BITS;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > 32767) r = 32767;
        if (r < 0) r = 0;
        return DATA_BITS'(r);
    endfunction

    // Forward pass over the shadow state; queues the output neurons.
    task automatic predict_forward_pass;
        int nw;
        int src;
        int dst;
        int nf;
        t_neuron_out o;
        nw  = weight_layers();
        src = 0;
        for (int l = 0; l < nw; l++) begin
            dst = 1 - src;
            for (int r = 0; r < clamped_size(l + 1); r++) begin
                act_mem[dst][r] = neuron_activation(l, r, clamped_size(l), src);
                if (dst == 0) ping_set[r] = 1'b1;
            end
            src = dst;
        end
        nf = clamped_size(nw);
        for (int k = 0; k < nf; k++) begin
            o.value = act_mem[src][k];
            o.index = IDX_W'(k);
            o.last  = (k == nf - 1);
            expected_outputs.push_back(o);
        end
    endtask

    // Send one item on the input stream and update the shadow state.
    task automatic send_item(input t_action action, input int lsel, input int row,
                             input int col, input logic [DATA_BITS-1:0] value,
                             input bit last);
        int gap;
        gap = send_gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {6'b0, value, IDX_W'(col), IDX_W'(row), LSEL_W'(lsel)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        case (action)
            ACT_LOAD_WEIGHT: begin
                weight_mem[lsel][row][col] = value;
                weight_set[lsel][row][col] = 1'b1;
            end
            ACT_LOAD_BIAS: begin
                bias_mem[lsel][row] = value;
                bias_set[lsel][row] = 1'b1;
            end
            ACT_ELEMENT: begin
                act_mem[0][row] = value;
                ping_set[row]   = 1'b1;
                if (last) predict_forward_pass();
            end
            default: ;
        endcase
    endtask

    // Stop sending and wait until every expected neuron has come out.
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index < NUM_CFG)
            cfg_shadow[index] = (index == CFG_LAYER_COUNT) ? (data & 5'h7) : data;
    endtask

    task automatic set_network(input logic [CFG_DATA_W-1:0] lc, input logic [CFG_DATA_W-1:0] s0,
                               input logic [CFG_DATA_W-1:0] s1, input logic [CFG_DATA_W-1:0] s2,
                               input logic [CFG_DATA_W-1:0] s3, input logic [CFG_DATA_W-1:0] s4);
        wait_drained();
        write_register(CFG_LAYER_COUNT, lc);
        write_register(CFG_SIZE_INPUT, s0);
        write_register(CFG_SIZE_HID1, s1);
        write_register(CFG_SIZE_HID2, s2);
        write_register(CFG_SIZE_HID3, s3);
        write_register(CFG_SIZE_FINAL, s4);
    endtask

    function automatic logic [DATA_BITS-1:0] draw_value();
        case ($urandom_range(0, 3))
            0: return DATA_BITS'($urandom);
            1: return DATA_BITS'($urandom_range(0, 512) - 256);
            2: case ($urandom_range(0, 3))
                   0: return 16'h7FFF;
                   1: return 16'h8000;
                   2: return 16'h0000;
                   default: return 16'h0001;
               endcase
            default: return DATA_BITS'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    // One well-formed vector: missing parameters, some noise, then the elements.
    task automatic run_vector(input bit rewrite_all);
        int nw;
        int ns;
        int order [MAX_WIDTH];
        int chosen [$];
        int tmp;
        int j;
        nw = weight_layers();
        for (int l = 0; l < nw; l++)
            for (int r = 0; r < clamped_size(l + 1); r++) begin
                for (int c = 0; c < clamped_size(l); c++)
                    if (!weight_set[l][r][c] || $urandom_range(0, 15) == 0)
                        send_item(ACT_LOAD_WEIGHT, l, r, c, draw_value(), $urandom_range(0, 1));
                if (!bias_set[l][r] || $urandom_range(0, 7) == 0)
                    send_item(ACT_LOAD_BIAS, l, r, $urandom_range(0, 15), draw_value(),
                              $urandom_range(0, 1));
            end
        // Noise: stray loads anywhere and the unused action.
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
                0: send_item(ACT_LOAD_WEIGHT, $urandom_range(0, 3), $urandom_range(0, 15),
                             $urandom_range(0, 15), draw_value(), $urandom_range(0, 1));
                1: send_item(ACT_LOAD_BIAS, $urandom_range(0, 3), $urandom_range(0, 15),
                             $urandom_range(0, 15), draw_value(), $urandom_range(0, 1));
                default: send_item(ACT_UNUSED, $urandom_range(0, 3), $urandom_range(0, 15),
                                   $urandom_range(0, 15), draw_value(), $urandom_range(0, 1));
            endcase
        end
        // Elements in shuffled order; stale ones may be left out.
        ns = clamped_size(0);
        for (int i = 0; i < MAX_WIDTH; i++) order[i] = i;
        for (int i = MAX_WIDTH - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i]; order[i] = order[j]; order[j] = tmp;
        end
        for (int i = 0; i < MAX_WIDTH; i++)
            if (order[i] < ns && (rewrite_all || !ping_set[order[i]] || $urandom_range(0, 3) != 0))
                chosen.push_back(order[i]);
        // The final element sometimes lands outside the used input range.
        if (chosen.size() == 0 || $urandom_range(0, 5) == 0)
            chosen.push_back($urandom_range(0, 15));
        for (int i = 0; i < chosen.size(); i++)
            send_item(ACT_ELEMENT, $urandom_range(0, 3), chosen[i], $urandom_range(0, 15),
                      draw_value(), i == chosen.size() - 1);
    endtask

    // Saturation both ways, ReLU, round half up, ignored items.
    task automatic test_arithmetic_edges;
        set_network(5'd2, 5'd1, 5'd4, 5'd16, 5'd16, 5'd16);
        send_item(ACT_LOAD_WEIGHT, 0, 0, 0, 16'h7FFF, 1'b0);
        send_item(ACT_LOAD_WEIGHT, 0, 1, 0, 16'h8000, 1'b1);
        send_item(ACT_LOAD_WEIGHT, 0, 2, 0, 16'h0001, 1'b0);
        send_item(ACT_LOAD_WEIGHT, 0, 3, 0, 16'hFFFF, 1'b0);
        send_item(ACT_LOAD_BIAS, 0, 0, 15, 16'h7FFF, 1'b1);
        send_item(ACT_LOAD_BIAS, 0, 1, 0, 16'h0000, 1'b0);
        send_item(ACT_LOAD_BIAS, 0, 2, 0, 16'h0000, 1'b0);
        send_item(ACT_LOAD_BIAS, 0, 3, 0, 16'h0001, 1'b0);
        send_item(ACT_UNUSED, 3, 15, 15, 16'hFFFF, 1'b1);
        send_item(ACT_ELEMENT, 3, 0, 15, 16'h0080, 1'b1);
        send_item(ACT_ELEMENT, 0, 0, 0, 16'h8000, 1'b1);
        send_item(ACT_ELEMENT, 0, 0, 0, 16'h7FFF, 1'b1);
    endtask

    // Out-of-range register values clamp; spare indexes are ignored.
    task automatic test_register_clamping;
        set_network(5'd7, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31);
        wait_drained();
        write_register(CFG_SPARE_LO, 5'h1F);
        write_register(CFG_SPARE_HI, 5'h1F);
        run_vector(1'b1);
        set_network(5'd1, 5'd17, 5'd1, 5'd1, 5'd1, 5'd1);
        run_vector(1'b1);
    endtask

    // Widest output layer: sixteen neurons leave one at a time under stalls.
    task automatic test_full_width;
        send_gaps = 1'b0;
        stall_on  = 1'b1;
        set_network(5'd2, 5'd1, 5'd16, 5'd1, 5'd1, 5'd1);
        run_vector(1'b1);
    endtask

    // Partial rewrites read back activations left in the ping buffer.
    task automatic test_stale_activations;
        set_network(5'd3, 5'd4, 5'd4, 5'd3, 5'd1, 5'd1);
        run_vector(1'b1);
        send_item(ACT_ELEMENT, 0, 1, 0, draw_value(), 1'b1);
        run_vector(1'b0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] draw_size();
        if ($urandom_range(0, 7) == 0) return CFG_DATA_W'(0);
        return CFG_DATA_W'($urandom_range(1, 4));
    endfunction

    task automatic test_random_vectors;
        int start_items;
        int start_outputs;
        start_items   = items_sent;
        start_outputs = outputs_seen;
        while (items_sent - start_items < RANDOM_ITEMS
               || outputs_seen - start_outputs < RANDOM_RESULTS) begin
            if ($urandom_range(0, 2) != 0)
                set_network(CFG_DATA_W'($urandom_range(0, 7)), draw_size(), draw_size(),
                            draw_size(), draw_size(), draw_size());
            send_gaps = $urandom_range(0, 3) != 0;
            stall_on  = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 3)) run_vector($urandom_range(0, 1));
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_CFG; i++) cfg_shadow[i] = 5'd16;
        cfg_shadow[CFG_LAYER_COUNT] = 5'd2;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_gaps = 1'b1;
        stall_on  = 1'b1;
        test_arithmetic_edges();
        test_register_clamping();
        test_full_width();
        test_stale_activations();
        test_random_vectors();
        wait_drained();
        if (err_count == 0) begin
            $display("tb_dense_relu_mlp_inference: clean");
        end else begin
            $display("tb_dense_relu_mlp_inference: errors");
        end
        $finish;
    end

endmodule
